>>> rtl/vos_pkg.sv
// shared types, constants and codes for the vendor option stripper
`default_nettype none
package vos_pkg;

  localparam int HOLD_DEPTH      = 8;
  localparam int HOLD_AW         = 3;
  localparam int CNT_W           = 4;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VENDOR_CODE  = 3'd0,
    CFG_ENTERPRISE   = 3'd1,
    CFG_RELAY_FWD    = 3'd2,
    CFG_RELAY_REPLY  = 3'd3,
    CFG_PLAIN_HDR    = 3'd4,
    CFG_RELAY_HDR    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_OPTION  = 3'd2,
    PH_SKIP    = 3'd3,
    PH_DISCARD = 3'd4,
    PH_PASS    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_REMOVED   = 2'd0,
    ST_CUT       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  localparam logic [15:0] RST_VENDOR_CODE = 16'd17;
  localparam logic [31:0] RST_ENTERPRISE  = 32'd2495;
  localparam logic [7:0]  RST_RELAY_FWD   = 8'd12;
  localparam logic [7:0]  RST_RELAY_REPLY = 8'd13;
  localparam logic [7:0]  RST_PLAIN_HDR   = 8'd4;
  localparam logic [7:0]  RST_RELAY_HDR   = 8'd34;

  typedef struct packed {
    logic [15:0] vendor_code;
    logic [31:0] enterprise;
    logic [7:0]  relay_fwd;
    logic [7:0]  relay_reply;
    logic [7:0]  plain_hdr;
    logic [7:0]  relay_hdr;
  } cfg_t;

  // walker to hold buffer: byte write and result batch
  typedef struct packed {
    logic               wr_en;
    logic [HOLD_AW-1:0] wr_addr;
    logic [CNT_W-1:0]   rel_cnt;
    logic               bare;
    logic               eom;
    logic [1:0]         status;
  } cmd_t;

  typedef logic [HOLD_DEPTH-1:0][7:0] hold_arr_t;

endpackage
`default_nettype wire

>>> rtl/vos_cfg_regs.sv
// configuration register bank
`default_nettype none
module vos_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [vos_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [vos_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output vos_pkg::cfg_t                         cfg_o
);
  import vos_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vendor_code <= RST_VENDOR_CODE;
      cfg_q.enterprise  <= RST_ENTERPRISE;
      cfg_q.relay_fwd   <= RST_RELAY_FWD;
      cfg_q.relay_reply <= RST_RELAY_REPLY;
      cfg_q.plain_hdr   <= RST_PLAIN_HDR;
      cfg_q.relay_hdr   <= RST_RELAY_HDR;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VENDOR_CODE: cfg_q.vendor_code <= cfg_data_i[15:0];
        CFG_ENTERPRISE:  cfg_q.enterprise  <= cfg_data_i[31:0];
        CFG_RELAY_FWD:   cfg_q.relay_fwd   <= cfg_data_i[7:0];
        CFG_RELAY_REPLY: cfg_q.relay_reply <= cfg_data_i[7:0];
        CFG_PLAIN_HDR:   cfg_q.plain_hdr   <= cfg_data_i[7:0];
        CFG_RELAY_HDR:   cfg_q.relay_hdr   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> rtl/vos_walker.sv
// option walker: header count, tlv parse, enterprise match
`default_nettype none
module vos_walker #(
  parameter int LENGTH_BITS = vos_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                final_i,
  input  wire vos_pkg::cfg_t       cfg_i,
  input  wire vos_pkg::hold_arr_t  held_i,
  output vos_pkg::cmd_t            cmd_o
);
  import vos_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [7:0]             hr_q, hr_d;
  logic [LENGTH_BITS-1:0] obl_q, obl_d;
  logic [HOLD_AW-1:0]     hc_q, hc_d;
  cmd_t                   cmd;

  logic [7:0]             hdr_len;
  logic [7:0]             hr_dec;
  logic [LENGTH_BITS-1:0] obl_dec;
  logic [15:0]            code16;
  logic [15:0]            len_a;
  logic [15:0]            len_b_m4;
  logic [31:0]            ent;
  logic [CNT_W-1:0]       rel_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      hr_q    <= '0;
      obl_q   <= '0;
      hc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      hr_q    <= hr_d;
      obl_q   <= obl_d;
      hc_q    <= hc_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hr_d    = hr_q;
    obl_d   = obl_q;
    hc_d    = hc_q;
    cmd     = '0;

    hdr_len  = (byte_i == cfg_i.relay_fwd || byte_i == cfg_i.relay_reply) ?
               cfg_i.relay_hdr : cfg_i.plain_hdr;
    hr_dec   = hr_q - 8'd1;
    obl_dec  = obl_q - LENGTH_BITS'(1);
    code16   = {held_i[0], held_i[1]};
    len_a    = {held_i[2], byte_i};
    len_b_m4 = {held_i[2], held_i[3]} - 16'd4;
    ent      = {held_i[4], held_i[5], held_i[6], byte_i};
    rel_n    = {1'b0, hc_q} + CNT_W'(1);

    if (fire_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          // zero header length acts as one
          hr_d = (hdr_len == 8'd0) ? 8'd0 : hdr_len - 8'd1;
          phase_d = (hr_d != 8'd0) ? PH_HEADER : PH_OPTION;
          cmd.wr_en = 1'b1;
          cmd.rel_cnt = CNT_W'(1);
          cmd.status = (hr_d != 8'd0) ? ST_MALFORMED : ST_NOT_FOUND;
        end
        PH_HEADER: begin
          hr_d = hr_dec;
          if (hr_dec == 8'd0) phase_d = PH_OPTION;
          cmd.wr_en = 1'b1;
          cmd.rel_cnt = CNT_W'(1);
          cmd.status = (hr_dec != 8'd0) ? ST_MALFORMED : ST_NOT_FOUND;
        end
        PH_SKIP: begin
          obl_d = obl_dec;
          if (obl_dec == '0) phase_d = PH_OPTION;
          cmd.wr_en = 1'b1;
          cmd.rel_cnt = CNT_W'(1);
          cmd.status = (obl_dec != '0) ? ST_MALFORMED : ST_NOT_FOUND;
        end
        PH_DISCARD: begin
          obl_d = obl_dec;
          if (obl_dec == '0) phase_d = PH_PASS;
          cmd.status = (obl_dec != '0) ? ST_CUT : ST_REMOVED;
          if (final_i) begin
            cmd.bare = 1'b1;
            cmd.rel_cnt = CNT_W'(1);
          end
        end
        PH_PASS: begin
          cmd.wr_en = 1'b1;
          cmd.rel_cnt = CNT_W'(1);
          cmd.status = ST_REMOVED;
        end
        PH_OPTION: begin
          cmd.wr_en = 1'b1;
          cmd.wr_addr = hc_q;
          priority if (hc_q < HOLD_AW'(3)) begin
            // option code and first length byte
            cmd.status = ST_MALFORMED;
            if (final_i) cmd.rel_cnt = rel_n;
            else hc_d = hc_q + HOLD_AW'(1);
          end else if (hc_q == HOLD_AW'(3)) begin
            if (code16 == cfg_i.vendor_code && len_a >= 16'd4) begin
              cmd.status = ST_NOT_FOUND;
              if (final_i) cmd.rel_cnt = rel_n;
              else hc_d = hc_q + HOLD_AW'(1);
            end else begin
              cmd.rel_cnt = rel_n;
              hc_d = '0;
              obl_d = LENGTH_BITS'(len_a);
              phase_d = (len_a != 16'd0) ? PH_SKIP : PH_OPTION;
              cmd.status = (len_a != 16'd0) ? ST_MALFORMED : ST_NOT_FOUND;
            end
          end else if (hc_q < HOLD_AW'(HOLD_DEPTH - 1)) begin
            // enterprise bytes; cut short counts as not found
            cmd.status = ST_NOT_FOUND;
            if (final_i) cmd.rel_cnt = rel_n;
            else hc_d = hc_q + HOLD_AW'(1);
          end else begin
            hc_d = '0;
            obl_d = LENGTH_BITS'(len_b_m4);
            if (ent == cfg_i.enterprise) begin
              cmd.wr_en = 1'b0;
              phase_d = (len_b_m4 != 16'd0) ? PH_DISCARD : PH_PASS;
              cmd.status = (len_b_m4 != 16'd0) ? ST_CUT : ST_REMOVED;
              if (final_i) begin
                cmd.bare = 1'b1;
                cmd.rel_cnt = CNT_W'(1);
              end
            end else begin
              cmd.rel_cnt = rel_n;
              phase_d = (len_b_m4 != 16'd0) ? PH_SKIP : PH_OPTION;
              cmd.status = (len_b_m4 != 16'd0) ? ST_MALFORMED : ST_NOT_FOUND;
            end
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase

      if (final_i) begin
        // message done: walker back to its start
        cmd.eom = 1'b1;
        phase_d = PH_TYPE;
        hr_d    = '0;
        obl_d   = '0;
        hc_d    = '0;
      end
    end
  end

  assign cmd_o = cmd;

endmodule
`default_nettype wire

>>> rtl/vos_hold_buf.sv
// hold buffer: keeps option bytes back and drains result batches
`default_nettype none
module vos_hold_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire vos_pkg::cmd_t  cmd_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           out_stall_i,
  output vos_pkg::hold_arr_t  held_o,
  output logic                free_o,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic                end_of_message_o,
  output logic [1:0]          strip_status_o
);
  import vos_pkg::*;

  hold_arr_t          held_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [HOLD_AW-1:0] idx_q;
  logic               bare_q;
  logic               eom_q;
  logic [1:0]         st_q;

  logic last;
  logic taken;

  assign last  = (({1'b0, idx_q} + CNT_W'(1)) == cnt_q);
  assign taken = out_valid_o && !out_stall_i;

  assign out_valid_o      = (cnt_q != '0);
  assign free_o           = (cnt_q == '0) || (taken && last);
  assign out_byte_o       = bare_q ? 8'd0 : held_q[idx_q];
  assign byte_valid_o     = !bare_q;
  assign end_of_message_o = last && eom_q;
  assign strip_status_o   = (last && eom_q) ? st_q : 2'd0;
  assign held_o           = held_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) held_q[cmd_i.wr_addr] <= byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      bare_q <= 1'b0;
      eom_q  <= 1'b0;
      st_q   <= '0;
    end else if (cmd_i.rel_cnt != '0) begin
      cnt_q  <= cmd_i.rel_cnt;
      idx_q  <= '0;
      bare_q <= cmd_i.bare;
      eom_q  <= cmd_i.eom;
      st_q   <= cmd_i.status;
    end else if (taken) begin
      if (last) cnt_q <= '0;
      else idx_q <= idx_q + HOLD_AW'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/vendor_option_stripper.sv
// top level of the dhcpv6 vendor option stripper
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | message_byte_i, final_byte_i
//  out     | source    | out_valid_o/out_stall_i | out_byte_o, byte_valid_o,
//          |           |                         | end_of_message_o, strip_status_o
//  cfg     | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// an item waits in the input register until the hold buffer is free, the walker handles it
// in the cycle it leaves and loads 0 to 8 results into the hold buffer; the first result
// is offered the cycle after
// the hold buffer drains one result per cycle while out_stall_i is low, so a byte that passes through
// sustains one item per cycle; a release of n held bytes holds the input until the last is taken
// reset clears walker and buffer control; configuration returns to defaults
// out stall holds the current result and backs up into in_stall_o
`default_nettype none
module vendor_option_stripper #(
  parameter int LENGTH_BITS = vos_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input item channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      message_byte_i,
  input  wire logic                            final_byte_i,
  // result item channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [7:0]                           out_byte_o,
  output logic                                 byte_valid_o,
  output logic                                 end_of_message_o,
  output logic [1:0]                           strip_status_o,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [vos_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [vos_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import vos_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;

  cfg_t      cfg;
  cmd_t      cmd;
  hold_arr_t held;
  logic      buf_free;
  logic      fire;
  logic      in_take;

  // the walker runs only when the buffer is empty or empties this cycle
  assign fire       = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !buf_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= message_byte_i;
      in_fin_q  <= final_byte_i;
    end
  end

  vos_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // header count, option parse and match
  vos_walker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .final_i (in_fin_q),
    .cfg_i   (cfg),
    .held_i  (held),
    .cmd_o   (cmd)
  );

  // held option bytes double as the result queue
  vos_hold_buf u_hold (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .byte_i           (in_byte_q),
    .out_stall_i      (out_stall_i),
    .held_o           (held),
    .free_o           (buf_free),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .end_of_message_o (end_of_message_o),
    .strip_status_o   (strip_status_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the vendor option stripper with a byte-level predictor
`timescale 1ns / 1ps
module tb_top;
  import vos_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  // cycles to let pass once the last result is out, before a register write or the end
  localparam int DRAIN_CYCLES = 16;
  // long receiver hold-off: starts once this many items went in, lasts this long
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 200000;

  // one byte waiting to be sent, or a marker that makes the sender wait for a full drain
  typedef struct packed {
    logic       pause;
    logic       fin;
    logic [7:0] data;
  } msg_item_t;

  // one result item as the block should produce it
  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       eom;
    logic [1:0] st;
  } strip_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] message_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       end_of_message_o;
  logic [1:0] strip_status_o;

  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_VENDOR_CODE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  vendor_option_stripper i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .message_byte_i   (message_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .end_of_message_o (end_of_message_o),
    .strip_status_o   (strip_status_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // bytes still to send, and results predicted but not yet seen
  msg_item_t  msg_bytes_q[$];
  strip_res_t expected_out_q[$];
  strip_res_t res_batch[$];

  int n_accepted = 0;
  int n_offered = 0;
  int n_errors = 0;
  int n_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // predictor copy of the registers
  logic [15:0] cfg_code = RST_VENDOR_CODE;
  logic [31:0] cfg_ent = RST_ENTERPRISE;
  logic [7:0]  cfg_fwd = RST_RELAY_FWD;
  logic [7:0]  cfg_reply = RST_RELAY_REPLY;
  logic [7:0]  cfg_plain_hdr = RST_PLAIN_HDR;
  logic [7:0]  cfg_relay_hdr = RST_RELAY_HDR;

  // predictor copy of the walker state
  phase_e      walk;
  logic [7:0]  hdr_left;
  logic [15:0] opt_left;
  logic [7:0]  held [HOLD_DEPTH];
  int          held_n;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_walk();
    walk = PH_TYPE;
    hdr_left = '0;
    opt_left = '0;
    held_n = 0;
    for (int i = 0; i < HOLD_DEPTH; i++) held[i] = 8'h00;
  endfunction

  function automatic void emit(input logic [7:0] d, input logic dv);
    strip_res_t r;
    r.data = d;
    r.dv = dv;
    r.eom = 1'b0;
    r.st = ST_REMOVED;
    res_batch.push_back(r);
  endfunction

  // held option bytes go out in order, followed by the current byte
  function automatic void release_held(input logic [7:0] mb);
    for (int i = 0; i < held_n; i++) emit(held[i], 1'b1);
    held_n = 0;
    emit(mb, 1'b1);
  endfunction

  // tag the last result with end and status; a message with nothing left gets a bare marker
  function automatic void close_msg(input status_e st);
    strip_res_t r;
    if (res_batch.size() == 0) emit(8'h00, 1'b0);
    r = res_batch[res_batch.size() - 1];
    r.eom = 1'b1;
    r.st = st;
    res_batch[res_batch.size() - 1] = r;
    clear_walk();
  endfunction

  // option phase: collect code, length and enterprise number before deciding
  function automatic void walk_option(input logic [7:0] mb, input logic fin);
    logic [15:0] len;
    logic [31:0] ent;
    if (held_n < 3) begin
      if (fin) begin
        release_held(mb);
        close_msg(ST_MALFORMED);
      end else begin
        held[held_n] = mb;
        held_n++;
      end
    end else if (held_n == 3) begin
      len = {held[2], mb};
      if ({held[0], held[1]} == cfg_code && len >= 16'd4) begin
        // candidate vendor option: keep holding for the enterprise number
        if (fin) begin
          release_held(mb);
          close_msg(ST_NOT_FOUND);
        end else begin
          held[3] = mb;
          held_n = 4;
        end
      end else begin
        release_held(mb);
        opt_left = len;
        if (fin) close_msg(opt_left != 0 ? ST_MALFORMED : ST_NOT_FOUND);
        else if (opt_left != 0) walk = PH_SKIP;
      end
    end else if (held_n < HOLD_DEPTH - 1) begin
      // enterprise number cut short by the end counts as not found
      if (fin) begin
        release_held(mb);
        close_msg(ST_NOT_FOUND);
      end else begin
        held[held_n] = mb;
        held_n++;
      end
    end else begin
      len = {held[2], held[3]};
      ent = {held[4], held[5], held[6], mb};
      opt_left = len - 16'd4;
      if (ent == cfg_ent) begin
        held_n = 0;
        if (fin) close_msg(opt_left != 0 ? ST_CUT : ST_REMOVED);
        else walk = (opt_left != 0) ? PH_DISCARD : PH_PASS;
      end else begin
        release_held(mb);
        if (fin) close_msg(opt_left != 0 ? ST_MALFORMED : ST_NOT_FOUND);
        else if (opt_left != 0) walk = PH_SKIP;
      end
    end
  endfunction

  // works out the results of one accepted item and queues them
  function automatic void predict_strip(input logic [7:0] mb, input logic fin);
    logic [7:0] h;
    res_batch.delete();
    case (walk)
      PH_TYPE: begin
        h = (mb == cfg_fwd || mb == cfg_reply) ? cfg_relay_hdr : cfg_plain_hdr;
        if (h == 0) h = 8'd1;
        hdr_left = h - 8'd1;
        walk = (hdr_left != 0) ? PH_HEADER : PH_OPTION;
        emit(mb, 1'b1);
        if (fin) close_msg(hdr_left != 0 ? ST_MALFORMED : ST_NOT_FOUND);
      end
      PH_HEADER: begin
        hdr_left = hdr_left - 8'd1;
        if (hdr_left == 0) walk = PH_OPTION;
        emit(mb, 1'b1);
        if (fin) close_msg(hdr_left != 0 ? ST_MALFORMED : ST_NOT_FOUND);
      end
      PH_SKIP: begin
        opt_left = opt_left - 16'd1;
        if (opt_left == 0) walk = PH_OPTION;
        emit(mb, 1'b1);
        if (fin) close_msg(opt_left != 0 ? ST_MALFORMED : ST_NOT_FOUND);
      end
      PH_DISCARD: begin
        opt_left = opt_left - 16'd1;
        if (opt_left == 0) walk = PH_PASS;
        if (fin) close_msg(opt_left != 0 ? ST_CUT : ST_REMOVED);
      end
      PH_PASS: begin
        emit(mb, 1'b1);
        if (fin) close_msg(ST_REMOVED);
      end
      default: walk_option(mb, fin);
    endcase
    foreach (res_batch[i]) expected_out_q.push_back(res_batch[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  // directed message: n bytes, first byte in the top used position
  function automatic void queue_bytes(input logic [79:0] bytes, input int n);
    msg_item_t it;
    for (int i = 0; i < n; i++) begin
      it.pause = 1'b0;
      it.fin = (i == n - 1);
      it.data = bytes[(n - 1 - i) * 8 +: 8];
      msg_bytes_q.push_back(it);
    end
  endfunction

  // mostly well-formed messages with random content, some cut short or with a noisy tail
  function automatic int queue_random_msg();
    logic [7:0]  m[$];
    logic [7:0]  t;
    logic [7:0]  h;
    logic [15:0] ocode;
    logic [15:0] olen;
    logic [31:0] oent;
    int          nh;
    int          nopt;
    int          body;
    int          k;
    int          cut;
    bit          stop;
    msg_item_t   it;
    k = $urandom_range(99);
    if (k < 25) t = cfg_fwd;
    else if (k < 40) t = cfg_reply;
    else t = rnd_byte();
    m.push_back(t);
    h = (t == cfg_fwd || t == cfg_reply) ? cfg_relay_hdr : cfg_plain_hdr;
    if (h == 0) h = 8'd1;
    nh = int'(h) - 1;
    stop = 1'b0;
    // very long headers are only entered, the message ends inside them
    if (nh > 24) begin
      nh = $urandom_range(6);
      stop = 1'b1;
    end
    repeat (nh) m.push_back(rnd_byte());
    nopt = stop ? 0 : $urandom_range(3);
    for (int i = 0; i < nopt && !stop; i++) begin
      k = $urandom_range(99);
      ocode = cfg_code;
      oent = cfg_ent;
      if (k < 45) begin
        olen = 16'(4 + $urandom_range(4));
      end else if (k < 60) begin
        // near miss on the enterprise number
        olen = 16'(4 + $urandom_range(3));
        if ($urandom_range(1) == 1) oent = cfg_ent ^ (32'h1 << $urandom_range(31));
        else oent = cfg_ent ^ ($urandom | 32'h1);
      end else if (k < 70) begin
        olen = 16'($urandom_range(3));
      end else begin
        ocode = 16'($urandom_range(65535));
        olen = 16'($urandom_range(5));
        if ($urandom_range(9) == 0) olen = 16'($urandom_range(65535));
      end
      m.push_back(ocode[15:8]);
      m.push_back(ocode[7:0]);
      m.push_back(olen[15:8]);
      m.push_back(olen[7:0]);
      body = int'(olen);
      if (ocode == cfg_code && olen >= 16'd4) begin
        m.push_back(oent[31:24]);
        m.push_back(oent[23:16]);
        m.push_back(oent[15:8]);
        m.push_back(oent[7:0]);
        body = body - 4;
      end
      // huge length: send a few bytes and end there
      if (body > 8) begin
        body = $urandom_range(8);
        stop = 1'b1;
      end
      repeat (body) m.push_back(rnd_byte());
    end
    if (!stop && $urandom_range(9) == 0) repeat ($urandom_range(6, 1)) m.push_back(rnd_byte());
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(m.size(), 1);
      while (m.size() > cut) m.pop_back();
    end
    foreach (m[i]) begin
      it.pause = 1'b0;
      it.fin = (i == m.size() - 1);
      it.data = m[i];
      msg_bytes_q.push_back(it);
    end
    return m.size();
  endfunction

  // random messages until the budget is used; optionally one drain pause halfway
  task automatic queue_random_phase(input int budget, input bit with_pause);
    int n;
    bit paused;
    msg_item_t it;
    n = 0;
    paused = 1'b0;
    while (n < budget) begin
      n += queue_random_msg();
      if (with_pause && !paused && n >= budget / 2) begin
        it.pause = 1'b1;
        it.fin = 1'b0;
        it.data = 8'h00;
        msg_bytes_q.push_back(it);
        paused = 1'b1;
      end
    end
  endtask

  // wait until nothing is queued, offered or expected, then a few more cycles
  task automatic wait_drained();
    do @(negedge clk_i);
    while (msg_bytes_q.size() != 0 || in_valid_i || expected_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_VENDOR_CODE: cfg_code = val[15:0];
      CFG_ENTERPRISE:  cfg_ent = val;
      CFG_RELAY_FWD:   cfg_fwd = val[7:0];
      CFG_RELAY_REPLY: cfg_reply = val[7:0];
      CFG_PLAIN_HDR:   cfg_plain_hdr = val[7:0];
      CFG_RELAY_HDR:   cfg_relay_hdr = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // full register set, written only once the block has drained
  task automatic apply_cfg(input logic [15:0] code, input logic [31:0] ent,
                           input logic [7:0] fwd, input logic [7:0] reply,
                           input logic [7:0] plain, input logic [7:0] relay);
    wait_drained();
    write_reg(CFG_VENDOR_CODE, {16'h0000, code});
    write_reg(CFG_ENTERPRISE, ent);
    write_reg(CFG_RELAY_FWD, {24'h0, fwd});
    write_reg(CFG_RELAY_REPLY, {24'h0, reply});
    write_reg(CFG_PLAIN_HDR, {24'h0, plain});
    write_reg(CFG_RELAY_HDR, {24'h0, relay});
  endtask

  // ---------------------------------------------------------------- driver

  // inputs change on the falling edge; an offered item stays put until taken
  always @(negedge clk_i) begin
    msg_item_t it;
    logic v;
    v = in_valid_i;
    if (rst_ni && (!in_valid_i || n_accepted == n_offered)) begin
      v = 1'b0;
      if (msg_bytes_q.size() != 0) begin
        if (msg_bytes_q[0].pause) begin
          // sender holds off until every predicted result has come out
          if (expected_out_q.size() == 0) it = msg_bytes_q.pop_front();
        end else if ($urandom_range(99) >= send_idle_pct) begin
          it = msg_bytes_q.pop_front();
          message_byte_i = it.data;
          final_byte_i = it.fin;
          n_offered++;
          v = 1'b1;
        end
      end
    end
    in_valid_i = v;
  end

  // receiver stall: random per mode, plus one long hold-off so the block backs up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i = 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  // both handshakes sampled on the rising edge
  always @(posedge clk_i) begin
    strip_res_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_out_q.size() == 0) begin
          $error("result with nothing expected: out_byte %0h byte_valid %0b end_of_message %0b",
                 out_byte_o, byte_valid_o, end_of_message_o);
          n_errors++;
        end else begin
          e = expected_out_q.pop_front();
          if (out_byte_o !== e.data) begin
            $error("out_byte expected %0h actual %0h", e.data, out_byte_o);
            n_errors++;
          end
          if (byte_valid_o !== e.dv) begin
            $error("byte_valid expected %0b actual %0b", e.dv, byte_valid_o);
            n_errors++;
          end
          if (end_of_message_o !== e.eom) begin
            $error("end_of_message expected %0b actual %0b", e.eom, end_of_message_o);
            n_errors++;
          end
          if (strip_status_o !== e.st) begin
            $error("strip_status expected %0d actual %0d", e.st, strip_status_o);
            n_errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_strip(message_byte_i, final_byte_i);
        n_accepted++;
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_walk();
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // sender idles less than the receiver
    send_idle_pct = 26;
    recv_idle_pct = 67;

    // directed: zero plain header acts as one, relay header of two
    apply_cfg(RST_VENDOR_CODE, RST_ENTERPRISE, RST_RELAY_FWD, RST_RELAY_REPLY, 8'd0, 8'd2);
    // relay message ending inside its header
    queue_bytes(80'h0c, 1);
    // type byte only, ends where the first option is due
    queue_bytes(80'hff, 1);
    // ends inside an option header
    queue_bytes(80'h00_00, 2);
    // vendor option whose enterprise number is cut off by the end
    queue_bytes(80'h01_0011_0004, 5);
    // removed option ending exactly at the end: bare end marker
    queue_bytes(80'h02_0011_0004_000009bf, 9);
    // removed option reaching past the end: message cut at the option start
    queue_bytes(80'h03_0011_0005_000009bf, 9);
    // kept option whose length reaches past the end
    queue_bytes(80'h0d_5a_0001_0002_aa, 7);

    // defaults, long relay header; the long receiver hold-off falls in here
    apply_cfg(RST_VENDOR_CODE, RST_ENTERPRISE, RST_RELAY_FWD, RST_RELAY_REPLY,
              RST_PLAIN_HDR, RST_RELAY_HDR);
    queue_random_phase(50, 1'b0);

    // all-ones extremes, smallest plain header and largest relay header
    apply_cfg(16'hffff, 32'hffff_ffff, 8'hff, 8'h00, 8'd1, 8'd255);
    queue_random_phase(35, 1'b0);

    // receiver idles less than the sender
    send_idle_pct = 67;
    recv_idle_pct = 26;

    // all-zeros codes, largest plain header, smallest relay header
    apply_cfg(16'h0000, 32'h0000_0000, 8'h80, 8'h7f, 8'd255, 8'd1);
    queue_random_phase(35, 1'b1);

    apply_cfg(16'($urandom_range(65535)), $urandom, rnd_byte(), rnd_byte(),
              8'($urandom_range(6, 1)), 8'($urandom_range(8, 1)));
    queue_random_phase(35, 1'b0);

    // back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_cfg(16'($urandom_range(65535)), $urandom, rnd_byte(), rnd_byte(),
              8'($urandom_range(6, 1)), 8'($urandom_range(8, 1)));
    queue_random_phase(45, 1'b0);

    wait_drained();
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vos_pkg.sv
rtl/vos_cfg_regs.sv
rtl/vos_walker.sv
rtl/vos_hold_buf.sv
rtl/vendor_option_stripper.sv
tb/tb_top.sv
